>>> hw/rtl/page_table_mapper_defines.svh
// assertion helpers shared by the checker
`ifndef PAGE_TABLE_MAPPER_DEFINES_SVH
`define PAGE_TABLE_MAPPER_DEFINES_SVH

// same-cycle implication, held off during reset
`define PTM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page_table_mapper check failed");

// next-cycle implication, held off during reset
`define PTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page_table_mapper check failed");

`endif

>>> hw/rtl/ptm_pkg.sv
package ptm_pkg;

  localparam int DEF_TABLE_PAGES = 64;
  localparam int ENTRY_W = 64;
  localparam int BASE_W = 40;
  localparam int FRAME_W = BASE_W + 1;
  localparam int IDX_W = 9;
  localparam int VA_IDX_W = 5 * IDX_W;
  localparam int VA_LO = 12;
  localparam int PAD_W = ENTRY_W - FRAME_W - IDX_W - 3;
  localparam int LEVEL_W = 3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic CFG_FIVE_LEVELS = 1'b0;
  localparam logic CFG_TABLE_BASE = 1'b1;

  localparam logic [ENTRY_W-1:0] PRESENT_BIT = 64'h1;
  localparam logic [ENTRY_W-1:0] HUGE_BIT = 64'h80;
  localparam logic [2:0] LINK_BITS = 3'b111;

  typedef struct packed {
    logic [ENTRY_W-1:0] vaddr;
    logic [ENTRY_W-1:0] paddr;
    logic [ENTRY_W-1:0] entry_flags;
    logic huge_page;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_addr;
    logic [ENTRY_W-1:0] entry_value;
    logic [1:0] status;
    logic last;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

>>> hw/rtl/ptm_store.sv
module ptm_store #(
  parameter int TABLE_PAGES = ptm_pkg::DEF_TABLE_PAGES,
  localparam int AW = $clog2(TABLE_PAGES) + ptm_pkg::IDX_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ptm_pkg::store_ctl_t          ctl,
  input  logic [AW-1:0]                addr,
  input  logic [ptm_pkg::ENTRY_W-1:0]  wr_data,
  output logic [ptm_pkg::ENTRY_W-1:0]  rd_data,
  output logic                         clearing
);

  localparam int DEPTH = TABLE_PAGES * (1 << ptm_pkg::IDX_W);

  logic [ptm_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [ptm_pkg::ENTRY_W-1:0] wd;

  // zeroing sweep after reset owns the write port
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clearing | ctl.wr_en;
    wa = clearing ? clr_addr : addr;
    wd = clearing ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> hw/rtl/ptm_walker.sv
module ptm_walker #(
  parameter int TABLE_PAGES = ptm_pkg::DEF_TABLE_PAGES,
  localparam int PW = $clog2(TABLE_PAGES),
  localparam int AW = PW + ptm_pkg::IDX_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         five_levels,
  input  logic [ptm_pkg::BASE_W-1:0]   table_base,
  input  logic                         clearing,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  ptm_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output ptm_pkg::rsp_t                rsp,
  output ptm_pkg::store_ctl_t          ctl,
  output logic [AW-1:0]                addr,
  output logic [ptm_pkg::ENTRY_W-1:0]  wr_data,
  input  logic [ptm_pkg::ENTRY_W-1:0]  rd_data
);

  localparam int NW = $clog2(TABLE_PAGES + 1);
  localparam int FW = ptm_pkg::FRAME_W;
  localparam int BW = ptm_pkg::BASE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t state, state_next;
  logic [ptm_pkg::LEVEL_W-1:0]  level, level_next;
  logic                         huge, huge_next;
  logic [ptm_pkg::VA_IDX_W-1:0] va_bits, va_bits_next;
  logic [ptm_pkg::ENTRY_W-1:0]  leaf, leaf_next;
  logic [PW-1:0]                page, page_next;
  logic [FW-1:0]                frame, frame_next;
  logic [NW-1:0]                nfp, nfp_next;
  logic                         rsp_valid_next;
  ptm_pkg::rsp_t                rsp_next;

  logic [ptm_pkg::IDX_W-1:0]    idx;
  logic                         out_free;
  logic                         accept;
  logic                         at_leaf;
  logic [BW-1:0]                ent_frame;
  logic [FW-1:0]                diff;
  logic                         outside;
  logic                         full;
  logic [FW-1:0]                alloc_frame;
  logic [ptm_pkg::ENTRY_W-1:0]  eaddr;
  logic [ptm_pkg::ENTRY_W-1:0]  link;

  assign req_stall = (state != S_IDLE) | clearing;
  assign accept = req_valid & ~req_stall;
  assign out_free = ~rsp_valid | ~rsp_stall;
  assign addr = {page, idx};

  always_comb begin
    case (level)
      3'd5:    idx = va_bits[4*ptm_pkg::IDX_W +: ptm_pkg::IDX_W];
      3'd4:    idx = va_bits[3*ptm_pkg::IDX_W +: ptm_pkg::IDX_W];
      3'd3:    idx = va_bits[2*ptm_pkg::IDX_W +: ptm_pkg::IDX_W];
      3'd2:    idx = va_bits[1*ptm_pkg::IDX_W +: ptm_pkg::IDX_W];
      default: idx = va_bits[0 +: ptm_pkg::IDX_W];
    endcase
  end

  always_comb begin
    at_leaf = (level == (huge ? 3'd2 : 3'd1));
    ent_frame = rd_data[51:12];
    diff = {1'b0, ent_frame} - {1'b0, table_base};
    // below the base borrows; otherwise must name a page of the store
    outside = diff[FW-1] | (diff[BW-1:0] >= BW'(TABLE_PAGES));
    full = (nfp >= NW'(TABLE_PAGES));
    alloc_frame = {1'b0, table_base} + FW'(nfp);
    eaddr = {{ptm_pkg::PAD_W{1'b0}}, frame, idx, 3'b000};
    link = {{ptm_pkg::PAD_W{1'b0}}, alloc_frame, 9'd0, ptm_pkg::LINK_BITS};
  end

  always_comb begin
    state_next = state;
    level_next = level;
    huge_next = huge;
    va_bits_next = va_bits;
    leaf_next = leaf;
    page_next = page;
    frame_next = frame;
    nfp_next = nfp;
    rsp_valid_next = rsp_valid & rsp_stall;
    rsp_next = rsp;
    ctl = '0;
    wr_data = leaf;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          level_next = five_levels ? 3'd5 : 3'd4;
          huge_next = req.huge_page;
          va_bits_next = req.vaddr[ptm_pkg::VA_LO +: ptm_pkg::VA_IDX_W];
          leaf_next = req.paddr | req.entry_flags
                      | (req.huge_page ? ptm_pkg::HUGE_BIT : '0);
          page_next = '0;
          frame_next = {1'b0, table_base};
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (at_leaf) begin
          if (out_free) begin
            ctl.wr_en = 1'b1;
            rsp_valid_next = 1'b1;
            rsp_next = '{entry_addr: eaddr, entry_value: leaf,
                         status: ptm_pkg::ST_OK, last: 1'b1};
            state_next = S_IDLE;
          end
        end else begin
          ctl.rd_en = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if ((rd_data & ptm_pkg::PRESENT_BIT) != '0) begin
          if (!outside) begin
            page_next = diff[PW-1:0];
            frame_next = {1'b0, ent_frame};
            level_next = level - 3'd1;
            state_next = S_READ;
          end else if (out_free) begin
            rsp_valid_next = 1'b1;
            rsp_next = '{entry_addr: eaddr, entry_value: rd_data,
                         status: ptm_pkg::ST_OUTSIDE, last: 1'b1};
            state_next = S_IDLE;
          end
        end else if (out_free) begin
          rsp_valid_next = 1'b1;
          if (full) begin
            rsp_next = '{entry_addr: eaddr, entry_value: rd_data,
                         status: ptm_pkg::ST_FULL, last: 1'b1};
            state_next = S_IDLE;
          end else begin
            // link a fresh table and step down into it
            ctl.wr_en = 1'b1;
            wr_data = link;
            rsp_next = '{entry_addr: eaddr, entry_value: link,
                         status: ptm_pkg::ST_OK, last: 1'b0};
            page_next = nfp[PW-1:0];
            frame_next = alloc_frame;
            nfp_next = nfp + NW'(1);
            level_next = level - 3'd1;
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nfp <= NW'(1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      nfp <= nfp_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    huge <= huge_next;
    va_bits <= va_bits_next;
    leaf <= leaf_next;
    page <= page_next;
    frame <= frame_next;
    rsp <= rsp_next;
  end

endmodule

>>> hw/rtl/page_table_mapper.sv
// Maps one virtual address per item into a 4- or 5-level x86-64 page table
// held in an internal store of TABLE_PAGES pages of 512 entries. Every entry
// written (table links and the leaf) comes out as one result item; the last
// result of an item has last set, and an error ends the item with one result
// of status full or outside. Taking the item is the first step; each table
// level is then a store read followed by an evaluate step on the registered
// read data, and the leaf write ends the walk. A 2 MiB map skips one table
// level, and the walk waits while a stalled result holds the output. The
// walker drives a single store address for both reads and writes. After
// reset the store is zeroed one entry a cycle; req_stall stays high
// meanwhile, while configuration writes are taken at any time.
module page_table_mapper #(
  parameter int TABLE_PAGES = ptm_pkg::DEF_TABLE_PAGES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  ptm_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ptm_pkg::rsp_t               rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [ptm_pkg::BASE_W-1:0]  cfg_data
);

  localparam int AW = $clog2(TABLE_PAGES) + ptm_pkg::IDX_W;

  logic                         five_levels;
  logic [ptm_pkg::BASE_W-1:0]   table_base;
  logic                         clearing;
  ptm_pkg::store_ctl_t          ctl;
  logic [AW-1:0]                addr;
  logic [ptm_pkg::ENTRY_W-1:0]  wr_data;
  logic [ptm_pkg::ENTRY_W-1:0]  rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      five_levels <= 1'b0;
      table_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptm_pkg::CFG_FIVE_LEVELS: five_levels <= cfg_data[0];
        ptm_pkg::CFG_TABLE_BASE:  table_base <= cfg_data;
        default: ;
      endcase
    end
  end

  ptm_walker #(.TABLE_PAGES(TABLE_PAGES)) u_walker (
    .clk        (clk),
    .rst        (rst),
    .five_levels(five_levels),
    .table_base (table_base),
    .clearing   (clearing),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .ctl        (ctl),
    .addr       (addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  ptm_store #(.TABLE_PAGES(TABLE_PAGES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .clearing(clearing)
  );

endmodule

>>> hw/rtl/ptm_checker.sv
`include "page_table_mapper_defines.svh"

module ptm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ptm_pkg::rsp_t rsp
);

  // a held result keeps its payload
  `PTM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // one item at a time: the walk closes the input right after an accept
  `PTM_ASSERT_NEXT(a_one_item, clk, rst, req_valid && !req_stall, req_stall)

  // an error always ends the item
  `PTM_ASSERT_NOW(a_err_last, clk, rst, rsp_valid && rsp.status != ptm_pkg::ST_OK, rsp.last)

  // results before the last are table links
  `PTM_ASSERT_NOW(a_link_form, clk, rst, rsp_valid && !rsp.last, rsp.status == ptm_pkg::ST_OK && rsp.entry_value[2:0] == ptm_pkg::LINK_BITS)

endmodule

bind page_table_mapper ptm_checker u_ptm_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

>>> dv/page_table_mapper_test.sv
module page_table_mapper_test;

  localparam int TABLE_PAGES = ptm_pkg::DEF_TABLE_PAGES;
  localparam int STORE_DEPTH = TABLE_PAGES * 512;
  localparam int EW = ptm_pkg::ENTRY_W;
  localparam int BW = ptm_pkg::BASE_W;
  localparam logic [EW-1:0] FRAME_FIELD = 64'h000f_ffff_ffff_f000;
  localparam logic [EW-1:0] INDEX_MASK = 64'h1ff;
  localparam logic [BW-1:0] HOME_BASE = 40'h00_0004_0000;
  localparam logic [BW-1:0] BASE_MAX = '1;
  localparam int DRAIN_CAP = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT = 10_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ptm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ptm_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = ptm_pkg::CFG_FIVE_LEVELS;
  logic [BW-1:0] cfg_data = '0;

  // mirror of the block's table store and allocator
  logic [EW-1:0] table_mirror [STORE_DEPTH];
  int unsigned free_page;
  logic five_mode;
  logic [BW-1:0] base_page;
  ptm_pkg::rsp_t expected_writes[$];
  ptm_pkg::rsp_t want_write;

  logic [35:0] prefix_pool [4];
  bit steady = 1'b0;
  bit rsp_taken = 1'b0;
  int unsigned rsp_hold = 0;

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen = 0;
  int unsigned outside_seen = 0;

  page_table_mapper u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [EW-1:0] page_addr(int unsigned page);
    return (64'(base_page) + 64'(page)) << ptm_pkg::VA_LO;
  endfunction

  function automatic int unsigned level_index(logic [EW-1:0] va, int level);
    return 32'((va >> (ptm_pkg::VA_LO + ptm_pkg::IDX_W * (level - 1))) & INDEX_MASK);
  endfunction

  function automatic ptm_pkg::req_t map_item(logic [63:0] va, logic [63:0] pa,
                                             logic [63:0] fl, logic huge);
    ptm_pkg::req_t item;
    item.vaddr = va;
    item.paddr = pa;
    item.entry_flags = fl;
    item.huge_page = huge;
    return item;
  endfunction

  // walk the mirrored tables and queue every result (entry writes and any error) the item causes
  task automatic predict_map(input ptm_pkg::req_t item);
    logic [EW-1:0] ent, eaddr, rel, link;
    int unsigned page, idx, slot;
    int level, stop;
    bit ended;
    page = 0;
    ended = 1'b0;
    level = five_mode ? 5 : 4;
    stop = item.huge_page ? 2 : 1;
    while (level > stop && !ended) begin
      idx = level_index(item.vaddr, level);
      slot = page * 512 + idx;
      ent = table_mirror[slot];
      eaddr = page_addr(page) + (64'(idx) << 3);
      if ((ent & ptm_pkg::PRESENT_BIT) != 0) begin
        // present entries are followed as tables, huge bit or not
        rel = ((ent & FRAME_FIELD) >> ptm_pkg::VA_LO) - 64'(base_page);
        if (rel >= 64'(TABLE_PAGES)) begin
          expected_writes.push_back(
            ptm_pkg::rsp_t'{eaddr, ent, ptm_pkg::ST_OUTSIDE, 1'b1});
          ended = 1'b1;
        end else begin
          page = 32'(rel);
        end
      end else if (free_page >= TABLE_PAGES) begin
        expected_writes.push_back(ptm_pkg::rsp_t'{eaddr, ent, ptm_pkg::ST_FULL, 1'b1});
        ended = 1'b1;
      end else begin
        page = free_page;
        free_page++;
        link = page_addr(page) | 64'(ptm_pkg::LINK_BITS);
        table_mirror[slot] = link;
        expected_writes.push_back(ptm_pkg::rsp_t'{eaddr, link, ptm_pkg::ST_OK, 1'b0});
      end
      level--;
    end
    if (!ended) begin
      idx = level_index(item.vaddr, level);
      slot = page * 512 + idx;
      link = item.paddr | item.entry_flags
             | (item.huge_page ? ptm_pkg::HUGE_BIT : '0);
      table_mirror[slot] = link;
      eaddr = page_addr(page) + (64'(idx) << 3);
      expected_writes.push_back(ptm_pkg::rsp_t'{eaddr, link, ptm_pkg::ST_OK, 1'b1});
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_map(input ptm_pkg::req_t item);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predict_map(item);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [BW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == ptm_pkg::CFG_FIVE_LEVELS) five_mode = value[0];
    else base_page = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits are junk on purpose, only bit 0 counts
  task automatic set_levels(input logic five);
    write_reg(ptm_pkg::CFG_FIVE_LEVELS, {39'({$urandom, $urandom}), five});
  endtask

  task automatic settle();
    int unsigned waited;
    @(negedge clk);
    req_valid <= 1'b0;
    waited = 0;
    while (expected_writes.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (expected_writes.size() != 0) begin
      note_mismatch($sformatf("%0d expected entry writes never came", expected_writes.size()));
      expected_writes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rsp_taken) begin
      rsp_hold = steady ? 0 : $urandom_range(0, 10);
      rsp_taken = 1'b0;
    end
    rsp_stall <= (rsp_hold != 0);
    if (rsp_hold != 0) rsp_hold--;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      rsp_taken = 1'b1;
      results_seen++;
      if (rsp.status == ptm_pkg::ST_FULL) full_seen++;
      if (rsp.status == ptm_pkg::ST_OUTSIDE) outside_seen++;
      if (expected_writes.size() == 0) begin
        note_mismatch($sformatf("result at %h with nothing expected", rsp.entry_addr));
      end else begin
        want_write = expected_writes.pop_front();
        if (rsp.entry_addr !== want_write.entry_addr)
          note_mismatch($sformatf("entry_addr %h, expected %h",
                                  rsp.entry_addr, want_write.entry_addr));
        if (rsp.entry_value !== want_write.entry_value)
          note_mismatch($sformatf("entry_value %h, expected %h",
                                  rsp.entry_value, want_write.entry_value));
        if (rsp.status !== want_write.status)
          note_mismatch($sformatf("status %0d, expected %0d", rsp.status, want_write.status));
        if (rsp.last !== want_write.last)
          note_mismatch($sformatf("last %b, expected %b", rsp.last, want_write.last));
      end
    end
  end

  // pooled prefixes keep most walks on tables that already exist
  function automatic ptm_pkg::req_t random_map();
    logic [63:0] va;
    logic huge;
    va = rand64();
    huge = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) >= 8) begin
      va[56:21] = prefix_pool[$urandom_range(0, 3)];
      if (huge) va[29] = ~va[29];
    end
    return map_item(va, rand64(), rand64(), huge);
  endfunction

  task automatic test_fresh_walks();
    settle();
    set_levels(1'b0);
    write_reg(ptm_pkg::CFG_TABLE_BASE, HOME_BASE);
    send_map(map_item(64'h0, 64'h0, 64'h0, 1'b0));
    send_map(map_item(64'h0, 64'h1000, 64'h3, 1'b0));
    send_map(map_item('1, '1, '1, 1'b0));
    // huge leaf that lands on store page 0, then followed as a table
    send_map(map_item(64'h20_0000, page_addr(0), 64'h1, 1'b1));
    send_map(map_item(64'h20_5000, rand64(), rand64(), 1'b0));
    // huge leaf far outside the store
    send_map(map_item(64'h40_0000, 64'hffff_ffff_ffe0_0000, 64'h1, 1'b1));
    send_map(map_item(64'h40_0000, 64'h0, 64'h0, 1'b0));
    // non-present huge leaf gets replaced by a fresh table
    send_map(map_item(64'h60_0000, 64'h0, 64'h0, 1'b1));
    send_map(map_item(64'h60_1000, 64'h7000, 64'h0, 1'b0));
  endtask

  task automatic test_five_level_walks();
    settle();
    set_levels(1'b1);
    send_map(map_item(64'h0, rand64(), rand64(), 1'b0));
    send_map(map_item(64'h01ff_0000_0000_0000, rand64(), rand64(), 1'b0));
    send_map(map_item(64'h0100_0000_0000_0000, rand64(), rand64(), 1'b1));
    send_map(map_item(64'h01ff_0000_0000_0000, rand64(), rand64(), 1'b0));
  endtask

  task automatic test_base_extremes();
    settle();
    write_reg(ptm_pkg::CFG_TABLE_BASE, BASE_MAX);
    send_map(map_item(64'h0, rand64(), rand64(), 1'b0));
    // links written here carry the frame past bit 51
    send_map(map_item(64'h00fe_0000_0000_0000, rand64(), rand64(), 1'b0));
    send_map(map_item(64'h00fe_0000_0000_0000, rand64(), rand64(), 1'b0));
    settle();
    write_reg(ptm_pkg::CFG_TABLE_BASE, '0);
    send_map(map_item(64'h00fe_0000_0000_0000, rand64(), rand64(), 1'b0));
    send_map(map_item(64'h0, rand64(), rand64(), 1'b0));
  endtask

  task automatic test_random_maps(input int count, input logic five,
                                  input logic [BW-1:0] base);
    settle();
    set_levels(five);
    write_reg(ptm_pkg::CFG_TABLE_BASE, base);
    for (int i = 0; i < count; i++) begin
      steady = ((i / 16) % 3 == 2);
      send_map(random_map());
    end
    steady = 1'b0;
  endtask

  task automatic test_store_exhaustion();
    int extra;
    settle();
    set_levels(1'b0);
    write_reg(ptm_pkg::CFG_TABLE_BASE, HOME_BASE);
    extra = 0;
    for (int n = 0; n < 120 && extra < 5; n++) begin
      if (free_page >= TABLE_PAGES) extra++;
      send_map(map_item(rand64(), rand64(), rand64(), extra == 2));
    end
  endtask

  initial begin
    foreach (table_mirror[i]) table_mirror[i] = '0;
    free_page = 1;
    five_mode = 1'b0;
    base_page = '0;
    foreach (prefix_pool[i]) prefix_pool[i] = 36'({$urandom, $urandom});
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_fresh_walks();
    test_five_level_walks();
    test_base_extremes();
    test_random_maps(70, 1'b0, HOME_BASE);
    test_random_maps(70, 1'b1, HOME_BASE);
    test_random_maps(40, 1'b0, HOME_BASE + 40'd1);
    test_store_exhaustion();
    settle();

    $display("mapped %0d requests over 4- and 5-level walks, shifted and extreme table bases",
             items_sent);
    $display("checked %0d entry writes, %0d with store full, %0d pointing outside the store",
             results_seen, full_seen, outside_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("run limit reached with %0d entry writes pending", expected_writes.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
